// ===== src/pip_pkg.sv =====
// Shared constants and types for the point-in-polygon test block.
package pip_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int QUEUE_DEPTH_DEF = 4;

	// Control bits that travel with each queued vertex.
	typedef struct packed {
		logic last;
		logic edge_a_en;
		logic edge_b_en;
	} pip_ctl_t;

	localparam int CTL_BITS = $bits(pip_ctl_t);

endpackage

// ===== src/pip_if.sv =====
// Valid/ready channel interfaces for vertex input and result output.
interface pip_vtx_if #(
	parameter int W = pip_pkg::COORD_BITS_DEF
);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] vertex_x;
	logic signed [W-1:0] vertex_y;
	logic signed [W-1:0] test_x;
	logic signed [W-1:0] test_y;
	logic                last_vertex;

	modport source (output valid, vertex_x, vertex_y, test_x, test_y, last_vertex,
		input ready);
	modport sink (input valid, vertex_x, vertex_y, test_x, test_y, last_vertex,
		output ready);
endinterface

interface pip_res_if;
	logic valid;
	logic ready;
	logic inside_res;

	modport source (output valid, inside_res, input ready);
	modport sink (input valid, inside_res, output ready);
endinterface

// ===== src/pip_front.sv =====
// Front end: accepts vertices, tracks first and previous vertex, forms edge operands.
module pip_front #(
	parameter int COORD_BITS = pip_pkg::COORD_BITS_DEF,
	localparam int DW = COORD_BITS + 1,
	localparam int EW = pip_pkg::CTL_BITS + 8 * DW
) (
	input  logic          clk,
	input  logic          arst_n,
	pip_vtx_if.sink       vtx,
	input  logic          q_full,
	output logic          q_push,
	output logic [EW-1:0] q_wdata
);

	logic signed [COORD_BITS-1:0] first_x_q, first_y_q;
	logic signed [COORD_BITS-1:0] prev_x_q, prev_y_q;
	logic                         awaiting_q;

	logic signed [COORD_BITS-1:0] fx, fy;
	logic signed [DW-1:0]         a_dtx, a_dy, a_dx, a_dty;
	logic signed [DW-1:0]         b_dtx, b_dy, b_dx, b_dty;
	pip_pkg::pip_ctl_t            ctl;
	logic                         accept;

	assign vtx.ready = !q_full;
	assign accept    = vtx.valid && !q_full;
	assign q_push    = accept;

	// The closing edge starts at the first vertex, which is this one on a new polygon.
	assign fx = awaiting_q ? vtx.vertex_x : first_x_q;
	assign fy = awaiting_q ? vtx.vertex_y : first_y_q;

	always_comb begin
		// Edge from the current vertex back to the previous one.
		a_dtx = DW'(vtx.test_x) - DW'(vtx.vertex_x);
		a_dy  = DW'(prev_y_q) - DW'(vtx.vertex_y);
		a_dx  = DW'(prev_x_q) - DW'(vtx.vertex_x);
		a_dty = DW'(vtx.test_y) - DW'(vtx.vertex_y);
		// Closing edge from the first vertex to the current one.
		b_dtx = DW'(vtx.test_x) - DW'(fx);
		b_dy  = DW'(vtx.vertex_y) - DW'(fy);
		b_dx  = DW'(vtx.vertex_x) - DW'(fx);
		b_dty = DW'(vtx.test_y) - DW'(fy);

		ctl.last      = vtx.last_vertex;
		ctl.edge_a_en = !awaiting_q &&
			((vtx.vertex_y > vtx.test_y) != (prev_y_q > vtx.test_y));
		ctl.edge_b_en = vtx.last_vertex &&
			((fy > vtx.test_y) != (vtx.vertex_y > vtx.test_y));
	end

	assign q_wdata = {ctl, a_dtx, a_dy, a_dx, a_dty, b_dtx, b_dy, b_dx, b_dty};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_x_q  <= '0;
			first_y_q  <= '0;
			prev_x_q   <= '0;
			prev_y_q   <= '0;
			awaiting_q <= 1'b1;
		end else if (accept) begin
			if (awaiting_q) begin
				first_x_q <= vtx.vertex_x;
				first_y_q <= vtx.vertex_y;
			end
			prev_x_q   <= vtx.vertex_x;
			prev_y_q   <= vtx.vertex_y;
			awaiting_q <= vtx.last_vertex;
		end
	end

endmodule

// ===== src/pip_queue.sv =====
// Small register queue between the front end and the back end.
module pip_queue #(
	parameter int W = 8,
	parameter int DEPTH = pip_pkg::QUEUE_DEPTH_DEF,
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         full,
	output logic         empty
);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ===== src/pip_back.sv =====
// Back end: cross-multiplied edge compares, crossing parity and result register.
module pip_back #(
	parameter int COORD_BITS = pip_pkg::COORD_BITS_DEF,
	localparam int DW = COORD_BITS + 1,
	localparam int PRW = 2 * DW,
	localparam int EW = pip_pkg::CTL_BITS + 8 * DW
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_empty,
	input  logic [EW-1:0] q_rdata,
	output logic          q_pop,
	pip_res_if.source     res
);

	pip_pkg::pip_ctl_t    ctl;
	logic signed [DW-1:0] a_dtx, a_dy, a_dx, a_dty;
	logic signed [DW-1:0] b_dtx, b_dy, b_dx, b_dty;

	logic                  valid_s1;
	pip_pkg::pip_ctl_t     ctl_s1;
	logic signed [PRW-1:0] a_lhs_s1, a_rhs_s1, b_lhs_s1, b_rhs_s1;
	logic                  a_neg_s1, b_neg_s1;

	logic parity_q;
	logic res_valid_q;
	logic res_q;
	logic cross_a, cross_b, fire_s1, load_s1;

	assign {ctl, a_dtx, a_dy, a_dx, a_dty, b_dtx, b_dy, b_dx, b_dty} = q_rdata;

	// Only a polygon's final vertex needs room in the result register.
	assign fire_s1 = valid_s1 && !(ctl_s1.last && res_valid_q && !res.ready);
	assign load_s1 = !valid_s1 || fire_s1;
	assign q_pop   = load_s1 && !q_empty;

	// A straddling edge never has zero y difference, so its sign picks the compare.
	assign cross_a = ctl_s1.edge_a_en &&
		(a_neg_s1 ? (a_lhs_s1 > a_rhs_s1) : (a_lhs_s1 < a_rhs_s1));
	assign cross_b = ctl_s1.edge_b_en &&
		(b_neg_s1 ? (b_lhs_s1 > b_rhs_s1) : (b_lhs_s1 < b_rhs_s1));

	always_ff @(posedge clk) begin
		if (q_pop) begin
			ctl_s1   <= ctl;
			a_lhs_s1 <= PRW'(a_dtx) * PRW'(a_dy);
			a_rhs_s1 <= PRW'(a_dx) * PRW'(a_dty);
			b_lhs_s1 <= PRW'(b_dtx) * PRW'(b_dy);
			b_rhs_s1 <= PRW'(b_dx) * PRW'(b_dty);
			a_neg_s1 <= a_dy[DW-1];
			b_neg_s1 <= b_dy[DW-1];
		end
		if (fire_s1 && ctl_s1.last) begin
			res_q <= parity_q ^ cross_a ^ cross_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			parity_q    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= !q_empty;
			end
			if (fire_s1) begin
				parity_q <= ctl_s1.last ? 1'b0 : (parity_q ^ cross_a ^ cross_b);
			end
			if (fire_s1 && ctl_s1.last) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res.valid      = res_valid_q;
	assign res.inside_res = res_q;

endmodule

// ===== src/point_in_polygon_test.sv =====
// Top level of the ray-casting point-in-polygon test.
//
// Usage: polygon vertices arrive on the vtx channel, one transaction per
// vertex, each carrying the test point and a last_vertex flag. A polygon is
// the run of vertices up to and including one with last_vertex set; that
// vertex produces exactly one transaction on the res channel whose inside_res
// is 1 when the point is inside by the even-odd rule. Other vertices produce
// nothing.
// Throughput: one vertex per cycle, sustained while res takes results. After
// the last vertex is accepted it is written into the queue, read into the
// multiply stage, and its compare and parity update then load the result.
// The front end and back end are split by a queue of QUEUE_DEPTH entries.
// When res is stalled, the back end holds the next last vertex, the queue
// fills and vtx.ready drops only once it is full; ordinary vertices keep
// draining behind a waiting result.
// Reset (arst_n low) empties the queue and pipeline, clears the parity and
// makes the next vertex the first of a new polygon.
module point_in_polygon_test #(
	parameter int COORD_BITS = pip_pkg::COORD_BITS_DEF,
	parameter int QUEUE_DEPTH = pip_pkg::QUEUE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	pip_vtx_if.sink   vtx,
	pip_res_if.source res
);

	localparam int EW = pip_pkg::CTL_BITS + 8 * (COORD_BITS + 1);

	logic          q_push, q_pop, q_full, q_empty;
	logic [EW-1:0] q_wdata, q_rdata;

	pip_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.vtx     (vtx),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_wdata (q_wdata)
	);

	pip_queue #(.W(EW), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	pip_back #(.COORD_BITS(COORD_BITS)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_rdata (q_rdata),
		.q_pop   (q_pop),
		.res     (res)
	);

endmodule

// ===== src/pip_checker.sv =====
// Port-level checks for the point-in-polygon test, bound to the top level.
module pip_checker (
	input logic clk,
	input logic arst_n,
	input logic vtx_valid,
	input logic vtx_ready,
	input logic vtx_last,
	input logic res_valid,
	input logic res_ready,
	input logic res_inside
);

	logic [7:0] pending_q;
	logic       last_acc, res_acc;

	assign last_acc = vtx_valid && vtx_ready && vtx_last;
	assign res_acc  = res_valid && res_ready;

	// Last vertices accepted whose results are not yet delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (last_acc && !res_acc) begin
			pending_q <= pending_q + 8'd1;
		end else if (res_acc && !last_acc) begin
			pending_q <= pending_q - 8'd1;
		end
	end

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_inside))
		else $error("result changed or dropped while stalled");

	a_res_owed: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> pending_q != 8'd0)
		else $error("result offered without an accepted last vertex");

	a_reset_quiet: assert property (@(posedge clk)
		!$past(arst_n) |-> !res_valid)
		else $error("result valid right after reset");

	a_no_backlog_stall: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q == 8'd0 && $past(pending_q) == 8'd0 && $past(arst_n) |-> vtx_ready)
		else $error("input stalled with no result outstanding");

endmodule

bind point_in_polygon_test pip_checker u_pip_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.vtx_valid  (vtx.valid),
	.vtx_ready  (vtx.ready),
	.vtx_last   (vtx.last_vertex),
	.res_valid  (res.valid),
	.res_ready  (res.ready),
	.res_inside (res.inside_res)
);

// ===== dv/pip_inside_checker.sv =====
// Checker that predicts the inside flag of each polygon from the vertex stream and compares it.
module pip_inside_checker #(
	parameter int W = pip_pkg::COORD_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	pip_vtx_if   vtx,
	pip_res_if   res,
	output int   errors,
	output int   pending,
	output int   results_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	// Predicted polygon state.
	logic signed [W-1:0] first_x, first_y;
	logic signed [W-1:0] prev_x, prev_y;
	logic                parity;
	logic                awaiting_first;

	bit inside_expected[$];
	int fail_count;
	int checked_count;

	// Exact form of the crossing test: the division by dy becomes a cross-multiplied
	// compare whose direction depends on the sign of dy.
	function automatic bit ray_hits_edge(longint xi, longint yi, longint xj, longint yj,
		longint tx, longint ty);
		longint dy, lhs, rhs;
		if ((yi > ty) == (yj > ty))
			return 1'b0;
		dy = yj - yi;
		lhs = (tx - xi) * dy;
		rhs = (xj - xi) * (ty - yi);
		if (dy > 0)
			return lhs < rhs;
		return lhs > rhs;
	endfunction

	task automatic trace_vertex(logic signed [W-1:0] x, logic signed [W-1:0] y,
		logic signed [W-1:0] tx, logic signed [W-1:0] ty, logic last);
		if (awaiting_first) begin
			first_x = x;
			first_y = y;
			parity = 1'b0;
		end else if (ray_hits_edge(x, y, prev_x, prev_y, tx, ty)) begin
			parity = ~parity;
		end
		if (last) begin
			if (ray_hits_edge(first_x, first_y, x, y, tx, ty))
				parity = ~parity;
			inside_expected.push_back(parity);
			parity = 1'b0;
			awaiting_first = 1'b1;
		end else begin
			awaiting_first = 1'b0;
		end
		prev_x = x;
		prev_y = y;
	endtask

	initial begin
		fail_count = 0;
		checked_count = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_x = '0;
			first_y = '0;
			prev_x = '0;
			prev_y = '0;
			parity = 1'b0;
			awaiting_first = 1'b1;
			inside_expected.delete();
		end else begin
			if (vtx.valid && vtx.ready)
				trace_vertex(vtx.vertex_x, vtx.vertex_y, vtx.test_x, vtx.test_y,
					vtx.last_vertex);
			if (res.valid && res.ready) begin
				if (inside_expected.size() == 0) begin
					$error("inside_res: expected none, actual %0b", res.inside_res);
					fail_count++;
				end else begin
					bit want;
					want = inside_expected.pop_front();
					checked_count++;
					if (res.inside_res !== want) begin
						$error("inside_res: expected %0b, actual %0b", want, res.inside_res);
						fail_count++;
					end
				end
			end
		end
		errors <= fail_count;
		pending <= inside_expected.size();
		results_checked <= checked_count;
	end

endmodule

// ===== dv/point_in_polygon_test_tb.sv =====
// Top of the point-in-polygon testbench: clock, reset, vertex stimulus and verdict.
module point_in_polygon_test_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int W = pip_pkg::COORD_BITS_DEF;
	localparam int CYCLE_LIMIT = 200000;
	localparam int VERTEX_TARGET = 450;

	logic clk;
	logic arst_n;
	int   errors, pending, results_checked;
	int   vertices_sent, polygons_sent;
	int   cycle_count;
	bit   burst;
	bit   sink_fast;

	pip_vtx_if #(.W(W)) vtx_ch ();
	pip_res_if res_ch ();

	point_in_polygon_test DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.vtx    (vtx_ch),
		.res    (res_ch)
	);

	pip_inside_checker #(.W(W)) u_inside_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.vtx             (vtx_ch),
		.res             (res_ch),
		.errors          (errors),
		.pending         (pending),
		.results_checked (results_checked)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timed out after %0d cycles", cycle_count);
		$display("FAILED: results differ");
		$finish;
	end

	// Result side: random stalls, with fast stretches that switch now and then.
	initial begin
		int gap;
		res_ch.ready <= 1'b0;
		sink_fast = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 15) == 0)
				sink_fast = ~sink_fast;
			gap = sink_fast ? 0 : $urandom_range(0, 8);
			if (gap > 0) begin
				res_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!res_ch.valid);
		end
	end

	// Valid stays high across back-to-back transactions so it is never lowered and
	// raised within one step.
	task automatic send_vertex(logic signed [W-1:0] x, logic signed [W-1:0] y,
		logic signed [W-1:0] tx, logic signed [W-1:0] ty, logic last);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			vtx_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		vtx_ch.valid <= 1'b1;
		vtx_ch.vertex_x <= x;
		vtx_ch.vertex_y <= y;
		vtx_ch.test_x <= tx;
		vtx_ch.test_y <= ty;
		vtx_ch.last_vertex <= last;
		do @(posedge clk); while (!vtx_ch.ready);
		vertices_sent++;
		if (last)
			polygons_sent++;
	endtask

	// A span of zero means the full signed range.
	function automatic logic signed [W-1:0] rand_coord(int span);
		if (span == 0)
			return W'($urandom);
		return W'($urandom_range(0, 2 * span) - span);
	endfunction

	task automatic send_random_polygon();
		int n, span, mode;
		logic signed [W-1:0] tx, ty;
		mode = $urandom_range(0, 9);
		// Small spans make ties and vertices on the test line common.
		span = (mode < 4) ? 16 : (mode < 7) ? 2000 : 0;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
		burst = ($urandom_range(0, 4) == 0);
		tx = rand_coord(span);
		ty = rand_coord(span);
		for (int i = 0; i < n; i++) begin
			// Now and then the test point moves within a polygon.
			if (mode == 9) begin
				tx = rand_coord(span);
				ty = rand_coord(span);
			end
			send_vertex(rand_coord(span), rand_coord(span), tx, ty, i == n - 1);
		end
	endtask

	initial begin
		vertices_sent = 0;
		polygons_sent = 0;
		burst = 1'b0;
		vtx_ch.valid <= 1'b0;
		vtx_ch.vertex_x <= '0;
		vtx_ch.vertex_y <= '0;
		vtx_ch.test_x <= '0;
		vtx_ch.test_y <= '0;
		vtx_ch.last_vertex <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);

		// Single vertex at the corner of the range: closing edge is degenerate.
		send_vertex(-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, 1'b1);
		// Square with the point inside, then outside.
		send_vertex(-16'sd100, -16'sd100, 16'sd0, 16'sd0, 1'b0);
		send_vertex(16'sd100, -16'sd100, 16'sd0, 16'sd0, 1'b0);
		send_vertex(16'sd100, 16'sd100, 16'sd0, 16'sd0, 1'b0);
		send_vertex(-16'sd100, 16'sd100, 16'sd0, 16'sd0, 1'b1);
		send_vertex(-16'sd100, -16'sd100, 16'sd200, 16'sd0, 1'b0);
		send_vertex(16'sd100, -16'sd100, 16'sd200, 16'sd0, 1'b0);
		send_vertex(16'sd100, 16'sd100, 16'sd200, 16'sd0, 1'b0);
		send_vertex(-16'sd100, 16'sd100, 16'sd200, 16'sd0, 1'b1);
		// Triangle spanning the whole range, so the products are at their largest.
		send_vertex(-16'sd32768, -16'sd32768, -16'sd32768, 16'sd32767, 1'b0);
		send_vertex(16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767, 1'b0);
		send_vertex(16'sd0, 16'sd32767, 16'sd1, -16'sd32767, 1'b1);
		// The test point differs on every vertex.
		send_vertex(16'sd0, 16'sd0, 16'sd5, 16'sd5, 1'b0);
		send_vertex(16'sd20, 16'sd0, -16'sd32768, 16'sd3, 1'b0);
		send_vertex(16'sd0, 16'sd20, 16'sd32767, -16'sd32768, 1'b1);
		// Horizontal edges lying on the test line.
		send_vertex(16'sd0, 16'sd10, 16'sd25, 16'sd10, 1'b0);
		send_vertex(16'sd50, 16'sd10, 16'sd25, 16'sd10, 1'b0);
		send_vertex(16'sd50, 16'sd20, 16'sd25, 16'sd10, 1'b0);
		send_vertex(16'sd0, 16'sd20, 16'sd25, 16'sd10, 1'b1);
		// Two-vertex polygon across the full range.
		send_vertex(16'sd32767, 16'sd32767, 16'sd0, 16'sd0, 1'b0);
		send_vertex(-16'sd32768, -16'sd32768, 16'sd0, 16'sd0, 1'b1);
		// Test point sitting on a vertex.
		send_vertex(16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0);
		send_vertex(16'sd10, 16'sd0, 16'sd0, 16'sd0, 1'b0);
		send_vertex(16'sd0, 16'sd10, 16'sd0, 16'sd0, 1'b1);

		while (vertices_sent < VERTEX_TARGET)
			send_random_polygon();
		vtx_ch.valid <= 1'b0;

		// Let the checker count the final polygon before waiting on it.
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Sent %0d vertices in %0d polygons; %0d inside flags compared",
			vertices_sent, polygons_sent, results_checked);
		$display("Mixed small, medium and full-range coordinates, ties and moving test points");
		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// ===== files.f =====
src/pip_pkg.sv
src/pip_if.sv
src/pip_front.sv
src/pip_queue.sv
src/pip_back.sv
src/point_in_polygon_test.sv
src/pip_checker.sv
dv/pip_inside_checker.sv
dv/point_in_polygon_test_tb.sv
